// ===== sv/backslash_escape_decoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escape decoder
// Clocked concurrent checks with reset gating.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define BED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition seen at one edge holds at the next
`define BED_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) else $error(msg);

`endif

// ===== sv/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types and constants of the backslash escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam int unsigned MaxRes = 3;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] EscCode  = 8'h1B;
  localparam logic [1:0] HexDigits = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       stopped_by_c;
    logic       run_last;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] r;
    logic [1:0]        n;
  } dec_t;

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

endpackage

// ===== sv/bed_decoder.sv =====
// ----------------------------------------------------------------------------
// bed_decoder
// Escape state and the single-pass decode of one input byte into up to
// three result bytes.
// ----------------------------------------------------------------------------
module bed_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            arg_mode_i,
  input  logic            take_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output bed_pkg::dec_t   dec_o
);

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_OCT   = 2'd2,
    PH_HEX   = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [8:0] acc_q, acc_d;
  logic [1:0] left_q, left_d;
  logic       stop_q, stop_d;

  bed_pkg::res_t [bed_pkg::MaxRes-1:0] res;
  logic [1:0] cnt;
  logic       do_plain;
  logic       is_oct, is_hex;
  logic [3:0] hval;
  logic       named_hit;
  logic [7:0] named_val;

  assign is_oct = (byte_i >= "0") && (byte_i <= "7");

  always_comb begin
    is_hex = 1'b1;
    hval   = 4'd0;
    if (byte_i >= "0" && byte_i <= "9") begin
      hval = 4'(byte_i - "0");
    end else if (byte_i >= "a" && byte_i <= "f") begin
      hval = 4'(byte_i - "a" + 8'd10);
    end else if (byte_i >= "A" && byte_i <= "F") begin
      hval = 4'(byte_i - "A" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    named_hit = 1'b1;
    named_val = 8'h00;
    case (byte_i)
      "a":      named_val = 8'h07;
      "b":      named_val = 8'h08;
      "e", "E": named_val = bed_pkg::EscCode;
      "f":      named_val = 8'h0C;
      "n":      named_val = 8'h0A;
      "r":      named_val = 8'h0D;
      "t":      named_val = 8'h09;
      "v":      named_val = 8'h0B;
      "\\":     named_val = bed_pkg::ChBslash;
      default:  named_hit = 1'b0;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    left_d   = left_q;
    stop_d   = stop_q;
    res      = '0;
    cnt      = 2'd0;
    do_plain = 1'b0;
    if (!stop_q) begin
      case (phase_q)
        PH_PLAIN: do_plain = 1'b1;
        PH_ESC: begin
          phase_d = PH_PLAIN;
          if (named_hit) begin
            res[cnt] = bed_pkg::mk_byte(named_val); cnt = cnt + 2'd1;
          end else if (byte_i == "'" || byte_i == "\"" || byte_i == "?") begin
            if (arg_mode_i) begin
              res[cnt] = bed_pkg::mk_byte(bed_pkg::ChBslash); cnt = cnt + 2'd1;
            end
            res[cnt] = bed_pkg::mk_byte(byte_i); cnt = cnt + 2'd1;
          end else if (byte_i == bed_pkg::ChX) begin
            acc_d  = 9'd0;
            left_d = bed_pkg::HexDigits;
            phase_d = PH_HEX;
            if (last_i) begin
              res[cnt] = bed_pkg::mk_byte(bed_pkg::ChBslash); cnt = cnt + 2'd1;
              res[cnt] = bed_pkg::mk_byte(bed_pkg::ChX); cnt = cnt + 2'd1;
              phase_d = PH_PLAIN;
            end
          end else if (byte_i == "c" && arg_mode_i) begin
            stop_d = 1'b1;
          end else if (is_oct) begin
            acc_d   = {6'd0, byte_i[2:0]};
            left_d  = (byte_i[2:0] == 3'd0 && arg_mode_i) ? 2'd3 : 2'd2;
            phase_d = PH_OCT;
            if (last_i) begin
              res[cnt] = bed_pkg::mk_byte({5'd0, byte_i[2:0]}); cnt = cnt + 2'd1;
              phase_d = PH_PLAIN;
            end
          end else begin
            res[cnt] = bed_pkg::mk_byte(bed_pkg::ChBslash); cnt = cnt + 2'd1;
            res[cnt] = bed_pkg::mk_byte(byte_i); cnt = cnt + 2'd1;
          end
        end
        PH_OCT: begin
          if (is_oct && left_q != 2'd0) begin
            acc_d  = {acc_q[5:0], byte_i[2:0]};
            left_d = left_q - 2'd1;
            if (left_d == 2'd0 || last_i) begin
              res[cnt] = bed_pkg::mk_byte(acc_d[7:0]); cnt = cnt + 2'd1;
              phase_d = PH_PLAIN;
            end
          end else begin
            res[cnt] = bed_pkg::mk_byte(acc_q[7:0]); cnt = cnt + 2'd1;
            phase_d  = PH_PLAIN;
            do_plain = 1'b1;
          end
        end
        PH_HEX: begin
          if (is_hex && left_q != 2'd0) begin
            acc_d  = {acc_q[4:0], hval};
            left_d = left_q - 2'd1;
            if (left_d == 2'd0 || last_i) begin
              res[cnt] = bed_pkg::mk_byte(acc_d[7:0]); cnt = cnt + 2'd1;
              phase_d = PH_PLAIN;
            end
          end else begin
            if (left_q == bed_pkg::HexDigits) begin
              res[cnt] = bed_pkg::mk_byte(bed_pkg::ChBslash); cnt = cnt + 2'd1;
              res[cnt] = bed_pkg::mk_byte(bed_pkg::ChX); cnt = cnt + 2'd1;
            end else begin
              res[cnt] = bed_pkg::mk_byte(acc_q[7:0]); cnt = cnt + 2'd1;
            end
            phase_d  = PH_PLAIN;
            do_plain = 1'b1;
          end
        end
        default: phase_d = PH_PLAIN;
      endcase
    end
    if (do_plain) begin
      if (byte_i == bed_pkg::ChBslash && !last_i) begin
        phase_d = PH_ESC;
      end else begin
        res[cnt] = bed_pkg::mk_byte(byte_i); cnt = cnt + 2'd1;
      end
    end
    if (last_i) begin
      if (stop_d) begin
        res[cnt] = '0;
        res[cnt].stopped_by_c = 1'b1;
        cnt = cnt + 2'd1;
      end
      phase_d = PH_PLAIN;
      acc_d   = 9'd0;
      left_d  = 2'd0;
      stop_d  = 1'b0;
    end
    if (cnt != 2'd0) begin
      res[cnt - 2'd1].end_of_string = last_i;
      res[cnt - 2'd1].run_last      = 1'b1;
    end
  end

  assign dec_o.r = res;
  assign dec_o.n = cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      acc_q   <= 9'd0;
      left_q  <= 2'd0;
      stop_q  <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      stop_q  <= stop_d;
    end
  end

endmodule

// ===== sv/bed_outbuf.sv =====
// ----------------------------------------------------------------------------
// bed_outbuf
// Result register: holds the decoded bytes of one request and presents
// them one per cycle while pop_i is asserted, oldest first.
// ----------------------------------------------------------------------------
module bed_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  bed_pkg::dec_t dec_i,
  input  logic          pop_i,
  output bed_pkg::res_t head_o,
  output logic [1:0]    count_o
);

  bed_pkg::res_t [bed_pkg::MaxRes-1:0] ent_q, ent_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = dec_i.r;
      cnt_d = dec_i.n;
    end else if (pop_i) begin
      // advance
      ent_d[0] = ent_q[1];
      ent_d[1] = ent_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign head_o  = ent_q[0];
  assign count_o = cnt_q;

endmodule

// ===== sv/backslash_escape_decoder_core.sv =====
// The first result of a request shows in the cycle after it is accepted.
// One request per cycle while each yields at most one result and the output
// is not stalled; one yielding more holds the input until all but its last
// result are taken. Reset clears the escape state, the result count and
// argument_mode; the block is ready right after reset.
// ----------------------------------------------------------------------------
// backslash_escape_decoder_core
// Streaming C-style backslash escape decoder, one input byte per request.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_string_o,
  output logic       stopped_by_c_o,
  output logic       run_last_o
);

  logic          arg_mode_q;
  logic          take, pop;
  logic [1:0]    count;
  bed_pkg::dec_t dec;
  bed_pkg::res_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arg_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      arg_mode_q <= cfg_wdata_i;
    end
  end

  assign out_valid_o = (count != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (count == 2'd0) || (count == 2'd1 && out_ready_i);
  assign take        = in_valid_i && in_ready_o;

  bed_decoder u_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .arg_mode_i (arg_mode_q),
    .take_i     (take),
    .byte_i     (in_byte_i),
    .last_i     (in_last_i),
    .dec_o      (dec)
  );

  bed_outbuf u_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .dec_i   (dec),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (count)
  );

  assign out_byte_o      = head.out_byte;
  assign byte_valid_o    = head.byte_valid;
  assign end_of_string_o = head.end_of_string;
  assign stopped_by_c_o  = head.stopped_by_c;
  assign run_last_o      = head.run_last;

endmodule

// ===== sv/bed_checker.sv =====
// ----------------------------------------------------------------------------
// bed_checker
// Port-level checks of the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "backslash_escape_decoder_core_assert.svh"

module bed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       end_of_string_o,
  input logic       stopped_by_c_o,
  input logic       run_last_o
);

  `BED_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `BED_ASSERT(a_eos_run_last, !(out_valid_o && end_of_string_o) || run_last_o, "eos not last")
  `BED_ASSERT(a_stop_is_end, !(out_valid_o && stopped_by_c_o) || (end_of_string_o && !byte_valid_o), "stop flag misplaced")
  `BED_ASSERT(a_marker_clean, !(out_valid_o && !byte_valid_o) || (stopped_by_c_o && out_byte_o == 8'h00), "bad marker")
  `BED_ASSERT(a_ready_when_empty, out_valid_o || in_ready_o, "input blocked while empty")

endmodule

bind backslash_escape_decoder_core bed_checker u_bed_checker (.*);
